// File: rtl/core/wczps_pkg.sv
package wczps_pkg;

    // depth of the undecided-byte window
    localparam int WINDOW = 16;
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);

    localparam int BYTE_W = 8;
    localparam int THR_W  = 4;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(10);
    localparam logic [CNT_W-1:0] THR_MAX   = CNT_W'(WINDOW - 1);

    // commands from the sequencer to the window
    typedef struct packed {
        logic wr;
        logic pop;
        logic clr;
    } win_cmd_t;

    // one result handed to the output register
    typedef struct packed {
        logic              push;
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic              last;
    } out_push_t;

endpackage

// File: rtl/core/wczps_window.sv
module wczps_window (
    input  logic                             clk,
    input  logic                             rst_n,
    input  wczps_pkg::win_cmd_t              cmd,
    input  logic [wczps_pkg::BYTE_W-1:0]     wr_byte,
    input  logic [wczps_pkg::IDX_W-1:0]      rd_idx,
    output logic [wczps_pkg::BYTE_W-1:0]     rd_byte,
    output logic [wczps_pkg::CNT_W-1:0]      count
);

    logic [wczps_pkg::BYTE_W-1:0] buf_reg [wczps_pkg::WINDOW];
    logic [wczps_pkg::CNT_W-1:0]  cnt_reg;
    logic [wczps_pkg::CNT_W-1:0]  cnt_next;

    // shift line: pop moves every byte one place toward the head
    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            for (int k = 0; k < wczps_pkg::WINDOW - 1; k++)
            begin
                buf_reg[k] <= buf_reg[k + 1];
            end
        end
        else if (cmd.wr && (cnt_reg < wczps_pkg::CNT_W'(wczps_pkg::WINDOW)))
        begin
            buf_reg[cnt_reg[wczps_pkg::IDX_W-1:0]] <= wr_byte;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.pop)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - wczps_pkg::CNT_W'(1);
            end
        end
        else if (cmd.wr && (cnt_reg < wczps_pkg::CNT_W'(wczps_pkg::WINDOW)))
        begin
            cnt_next = cnt_reg + wczps_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign rd_byte = buf_reg[rd_idx];
    assign count   = cnt_reg;

endmodule

// File: rtl/core/wczps_ctrl.sv
module wczps_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             in_last,
    input  logic [wczps_pkg::CNT_W-1:0]      thr,
    input  logic                             out_free,
    output wczps_pkg::out_push_t             out_push,
    output wczps_pkg::win_cmd_t              win_cmd,
    output logic [wczps_pkg::IDX_W-1:0]      rd_idx,
    input  logic [wczps_pkg::BYTE_W-1:0]     rd_byte,
    input  logic [wczps_pkg::CNT_W-1:0]      count
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOP   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]                     state_reg, state_next;
    logic                           squeeze_reg, squeeze_next;
    logic                           phase_reg, phase_next;
    logic                           last_reg, last_next;
    logic [wczps_pkg::CNT_W-1:0]    scan_reg, scan_next;
    logic                           held_full_reg, held_full_next;
    logic [wczps_pkg::BYTE_W-1:0]   held_byte_reg, held_byte_next;

    logic                           emit;
    logic [wczps_pkg::BYTE_W-1:0]   emit_byte;
    logic                           stall;
    logic                           byte_nz;
    logic                           scan_end;
    logic                           scan_hit;
    logic [wczps_pkg::CNT_W-1:0]    run_len;

    // shared zero test: head byte, or the scanned byte during a scan
    assign rd_idx  = (state_reg == ST_SCAN) ? scan_reg[wczps_pkg::IDX_W-1:0] : '0;
    assign byte_nz = (rd_byte != '0);

    // an emit needs room when one byte is already held back
    assign stall    = held_full_reg && !out_free;
    assign scan_end = (scan_reg >= count);
    assign scan_hit = !scan_end && byte_nz;
    assign run_len  = scan_end ? count : scan_reg;

    always_comb
    begin
        state_next     = state_reg;
        squeeze_next   = squeeze_reg;
        phase_next     = phase_reg;
        last_next      = last_reg;
        scan_next      = scan_reg;
        held_full_next = held_full_reg;
        held_byte_next = held_byte_reg;
        win_cmd        = '0;
        out_push       = '0;
        in_ready       = 1'b0;
        emit           = 1'b0;
        emit_byte      = rd_byte;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    win_cmd.wr = 1'b1;
                    last_next  = in_last;
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                if (count == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (squeeze_reg)
                begin
                    if (!((phase_reg || byte_nz) && stall))
                    begin
                        win_cmd.pop = 1'b1;
                        if (phase_reg)
                        begin
                            phase_next = 1'b0;
                            emit       = 1'b1;
                        end
                        else if (!byte_nz)
                        begin
                            phase_next = 1'b1;
                        end
                        else
                        begin
                            squeeze_next = 1'b0;
                            emit         = 1'b1;
                        end
                    end
                end
                else if (byte_nz)
                begin
                    if (!stall)
                    begin
                        win_cmd.pop = 1'b1;
                        emit        = 1'b1;
                    end
                end
                else
                begin
                    // head is zero, so the pair scan starts at the next zero slot
                    scan_next  = wczps_pkg::CNT_W'(2);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end || scan_hit)
                begin
                    if (run_len > thr)
                    begin
                        squeeze_next = 1'b1;
                        phase_next   = 1'b0;
                        state_next   = ST_LOOP;
                    end
                    else if (scan_hit || last_reg)
                    begin
                        // short run: pass its leading zero and rescan
                        if (!stall)
                        begin
                            win_cmd.pop = 1'b1;
                            emit        = 1'b1;
                            emit_byte   = '0;
                            state_next  = ST_LOOP;
                        end
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    scan_next = scan_reg + wczps_pkg::CNT_W'(2);
                end
            end
            ST_FINISH:
            begin
                if (last_reg)
                begin
                    if (out_free)
                    begin
                        out_push.push  = 1'b1;
                        out_push.data  = held_full_reg ? held_byte_reg : '0;
                        out_push.valid = held_full_reg;
                        out_push.last  = 1'b1;
                        win_cmd.clr    = 1'b1;
                        squeeze_next   = 1'b0;
                        phase_next     = 1'b0;
                        held_full_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
                else if (held_full_reg)
                begin
                    if (out_free)
                    begin
                        out_push.push  = 1'b1;
                        out_push.data  = held_byte_reg;
                        out_push.valid = 1'b1;
                        out_push.last  = 1'b0;
                        held_full_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // one byte is held back so the final one can still take the last mark
        if (emit)
        begin
            if (held_full_reg)
            begin
                out_push.push  = 1'b1;
                out_push.data  = held_byte_reg;
                out_push.valid = 1'b1;
                out_push.last  = 1'b0;
            end
            held_full_next = 1'b1;
            held_byte_next = emit_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            squeeze_reg   <= 1'b0;
            phase_reg     <= 1'b0;
            last_reg      <= 1'b0;
            scan_reg      <= '0;
            held_full_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            squeeze_reg   <= squeeze_next;
            phase_reg     <= phase_next;
            last_reg      <= last_next;
            scan_reg      <= scan_next;
            held_full_reg <= held_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_byte_reg <= held_byte_next;
    end

endmodule

// File: rtl/core/wide_char_zero_pair_squeezer.sv
// channel   direction  payload                                   transfer
// s_*       in         tdata = in_byte, tlast = in_last          tvalid & tready
// m_*       out        tdata = out_byte, tuser = out_valid,      tvalid & tready
//                      tlast = out_last
// cfg_*     in         cfg_data = min_run_bytes                  cfg_valid & cfg_ready
//
// a byte is accepted, then the loop pops bytes until the window runs empty or a run
// scan is due; a run scan tests one pair slot at a time (up to window/2, the last one
// also pops a short run's zero), and a finish step ends the byte
// s_tready is high only while the sequencer is idle
// a stalled m_tready holds the sequencer once the held byte cannot move on
// reset clears control state; min_run_bytes resets to 10
module wide_char_zero_pair_squeezer (
    input  logic                            clk,
    input  logic                            rst_n,
    // raw message bytes
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wczps_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] in_byte
    input  logic                            s_tlast,
    // decoded bytes
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wczps_pkg::BYTE_W-1:0]    m_tdata,   // [7:0] out_byte
    output logic                            m_tuser,   // [0] out_valid
    output logic                            m_tlast,
    // threshold register write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wczps_pkg::THR_W-1:0]     cfg_data
);

    logic [wczps_pkg::THR_W-1:0]    min_run_reg;
    logic [wczps_pkg::CNT_W-1:0]    thr;

    wczps_pkg::win_cmd_t            win_cmd;
    wczps_pkg::out_push_t           out_push;
    logic [wczps_pkg::IDX_W-1:0]    rd_idx;
    logic [wczps_pkg::BYTE_W-1:0]   rd_byte;
    logic [wczps_pkg::CNT_W-1:0]    count;
    logic                           out_free;

    logic                           m_valid_reg;
    logic [wczps_pkg::BYTE_W-1:0]   m_data_reg;
    logic                           m_user_reg;
    logic                           m_last_reg;

    // threshold register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_run_reg <= wczps_pkg::THR_RESET;
        end
        else if (cfg_valid)
        begin
            min_run_reg <= cfg_data;
        end
    end

    // clamp so the window never overflows
    always_comb
    begin
        thr = wczps_pkg::CNT_W'(min_run_reg);
        if (thr > wczps_pkg::THR_MAX)
        begin
            thr = wczps_pkg::THR_MAX;
        end
    end

    wczps_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (win_cmd),
        .wr_byte (s_tdata),
        .rd_idx  (rd_idx),
        .rd_byte (rd_byte),
        .count   (count)
    );

    wczps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_last  (s_tlast),
        .thr      (thr),
        .out_free (out_free),
        .out_push (out_push),
        .win_cmd  (win_cmd),
        .rd_idx   (rd_idx),
        .rd_byte  (rd_byte),
        .count    (count)
    );

    // output register: takes a new result when empty or being drained
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_push.push)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push.push)
        begin
            m_data_reg <= out_push.data;
            m_user_reg <= out_push.valid;
            m_last_reg <= out_push.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: tb/wide_char_zero_pair_squeezer_test.sv
module wide_char_zero_pair_squeezer_test;

    // one decoded result as it leaves the block
    typedef struct packed {
        logic [wczps_pkg::BYTE_W-1:0] data;
        logic                         valid;
        logic                         last;
    } dec_byte_t;

    // directed rows: a raw byte or a threshold write
    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                    kind;
        logic [wczps_pkg::BYTE_W-1:0] value;
        logic                         last;
        logic                         typed;   // use the hand-written result below
        dec_byte_t                    want;
    } row_t;

    localparam dec_byte_t NO_WANT    = '0;
    localparam int        DRAIN      = 200;   // worst case window rescan with margin
    localparam int        LONG_HOLD  = 300;
    localparam int        PHASES     = 9;
    localparam int        PER_PHASE  = 50;

    // thresholds walked by the random part, extremes included
    localparam logic [wczps_pkg::THR_W-1:0] PHASE_THR [PHASES] = '{
        4'd3, 4'd15, 4'd0, 4'd7, 4'd1, 4'd14, 4'd10, 4'd5, 4'd12
    };

    localparam row_t PLAN [27] = '{
        // lone bytes closing a message, then a plain byte
        '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}},
        '{ROW_BYTE, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}},
        '{ROW_BYTE, 8'h01, 1'b0, 1'b1, '{8'h01, 1'b1, 1'b0}},
        // twelve byte zero-pair run, squeezed once it passes ten
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'h80, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'h7F, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'h01, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'hFE, 1'b0, 1'b0, NO_WANT},
        // nonzero where a zero is due ends squeezing
        '{ROW_BYTE, 8'h55, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'h00, 1'b1, 1'b0, NO_WANT},
        // zero threshold: a lone zero squeezes to an empty closing result
        '{ROW_CFG,  8'h00, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
        // unpaired trailing zero of a squeezed run is dropped
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'h12, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
        // top threshold: short run cut by message end gets rescanned
        '{ROW_CFG,  8'h0F, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'h33, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_WANT},
        '{ROW_BYTE, 8'h44, 1'b1, 1'b0, NO_WANT}
    };

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [wczps_pkg::BYTE_W-1:0] s_tdata   = '0;
    logic                         s_tlast   = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [wczps_pkg::BYTE_W-1:0] m_tdata;
    logic                         m_tuser;
    logic                         m_tlast;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [wczps_pkg::THR_W-1:0]  cfg_data  = '0;

    // predictor state, mirrors the block between messages and within one
    logic [wczps_pkg::BYTE_W-1:0] undecided [$];
    logic                         squeezing    = 1'b0;
    logic                         want_payload = 1'b0;
    logic [wczps_pkg::THR_W-1:0]  thr_reg      = wczps_pkg::THR_RESET;

    dec_byte_t decoded_step [$];   // results of the latest accepted byte
    dec_byte_t decoded_due  [$];   // results still owed by the block

    int   mismatch_count = 0;
    int   random_sent    = 0;
    int   hold_left      = 0;
    logic calm           = 1'b0;   // no idling on either side
    logic long_hold_req  = 1'b0;

    always #5 clk = ~clk;

    wide_char_zero_pair_squeezer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    task automatic note_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic void emit_byte(input logic [wczps_pkg::BYTE_W-1:0] b);
        decoded_step.push_back('{b, 1'b1, 1'b0});
    endfunction

    // works out what one raw byte makes the block send
    function automatic void decode_step(input logic [wczps_pkg::BYTE_W-1:0] b,
                                        input logic l);
        int unsigned lim;
        int unsigned run;
        bit          ended;
        int          i;
        logic [wczps_pkg::BYTE_W-1:0] x;
        decoded_step.delete();
        lim = (thr_reg > wczps_pkg::WINDOW - 1) ? wczps_pkg::WINDOW - 1 : thr_reg;
        if (undecided.size() < wczps_pkg::WINDOW)
            undecided.push_back(b);
        while (undecided.size() > 0)
        begin
            if (squeezing)
            begin
                x = undecided.pop_front();
                if (!want_payload)
                begin
                    if (x == 0)
                        want_payload = 1'b1;
                    else
                    begin
                        // nonzero where a zero is due ends the run
                        squeezing = 1'b0;
                        emit_byte(x);
                    end
                end
                else
                begin
                    want_payload = 1'b0;
                    emit_byte(x);
                end
                continue;
            end
            if (undecided[0] != 0)
            begin
                emit_byte(undecided.pop_front());
                continue;
            end
            // length of the zero-pair run at the head of the window
            run   = undecided.size();
            ended = 1'b0;
            for (i = 0; i < undecided.size(); i += 2)
            begin
                if (undecided[i] != 0)
                begin
                    run   = i;
                    ended = 1'b1;
                    break;
                end
            end
            if (run > lim)
            begin
                squeezing    = 1'b1;
                want_payload = 1'b0;
                continue;
            end
            if (ended || l)
            begin
                emit_byte(undecided.pop_front());
                continue;
            end
            break;
        end
        if (l)
        begin
            if (decoded_step.size() == 0)
                decoded_step.push_back('{8'h00, 1'b0, 1'b1});
            else
                decoded_step[decoded_step.size() - 1].last = 1'b1;
            undecided.delete();
            squeezing    = 1'b0;
            want_payload = 1'b0;
        end
    endfunction

    // offers one raw byte and books its results once the transfer happens
    task automatic push_raw_byte(input logic [wczps_pkg::BYTE_W-1:0] b, input logic l,
                                 input logic typed, input dec_byte_t want);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        do @(posedge clk); while (!s_tready);
        decode_step(b, l);
        if (typed)
            decoded_due.push_back(want);
        else
            foreach (decoded_step[k])
                decoded_due.push_back(decoded_step[k]);
    endtask

    // stop offering and wait for the block to hand over everything owed
    task automatic settle();
        s_tvalid <= 1'b0;
        while (decoded_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_threshold(input logic [wczps_pkg::THR_W-1:0] v);
        settle();
        // a byte still pending in the window gives no sign, so let it finish
        repeat (DRAIN) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        thr_reg = v;
    endtask

    // one message: mostly zero-pair runs near the threshold, some noise
    task automatic send_message();
        logic [wczps_pkg::BYTE_W-1:0] msg [$];
        int segs;
        int kind;
        int len;
        int k;
        segs = $urandom_range(1, 4);
        repeat (segs)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                len = $urandom_range(0, 6);
                len = len + int'(thr_reg) - 3;
                if (len < 1)
                    len = 1;
                for (k = 0; k < len; k++)
                begin
                    if (k % 2 == 0 || $urandom_range(0, 7) == 0)
                        msg.push_back(8'h00);
                    else
                        msg.push_back(8'($urandom_range(1, 255)));
                end
            end
            else if (kind <= 7)
                repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(1, 255)));
            else if (kind == 8)
                repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom_range(0, 255)));
            else
                msg.push_back(8'h00);   // lone zero, often a trailing one
        end
        for (k = 0; k < msg.size(); k++)
        begin
            push_raw_byte(msg[k], k == msg.size() - 1, 1'b0, NO_WANT);
            random_sent++;
        end
    endtask

    // result side: compare each transfer, then pick the next ready level
    always @(posedge clk)
    begin
        dec_byte_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (decoded_due.size() == 0)
                note_mismatch($sformatf("result with nothing owed: data %02h valid %b last %b",
                                        m_tdata, m_tuser, m_tlast));
            else
            begin
                w = decoded_due.pop_front();
                if (m_tdata !== w.data)
                    note_mismatch($sformatf("out_byte %02h, want %02h", m_tdata, w.data));
                if (m_tuser !== w.valid)
                    note_mismatch($sformatf("out_valid %b, want %b", m_tuser, w.valid));
                if (m_tlast !== w.last)
                    note_mismatch($sformatf("out_last %b, want %b", m_tlast, w.last));
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (long_hold_req)
        begin
            // long stall so the window fills and the input backs up
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
            m_tready     <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            hold_left = $urandom_range(0, 6);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at the reset threshold and at both extremes
        foreach (PLAN[r])
        begin
            if (PLAN[r].kind == ROW_CFG)
                write_threshold(PLAN[r].value[wczps_pkg::THR_W-1:0]);
            else
                push_raw_byte(PLAN[r].value, PLAN[r].last, PLAN[r].typed, PLAN[r].want);
        end

        // random messages, one threshold per phase
        for (int p = 0; p < PHASES; p++)
        begin
            write_threshold(PHASE_THR[p]);
            calm = (p == PHASES - 1);
            if (p == 1)
                long_hold_req = 1'b1;
            while (random_sent < (p + 1) * PER_PHASE)
            begin
                if (p == 3 && random_sent >= p * PER_PHASE + PER_PHASE / 2
                    && random_sent < p * PER_PHASE + PER_PHASE / 2 + 4)
                    settle();   // sender waits for the block to run dry
                send_message();
            end
        end

        settle();
        repeat (DRAIN) @(posedge clk);
        if (decoded_due.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", decoded_due.size()));
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial
    begin
        #6000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
